// ----- hw/rtl/ssrp_pkg.sv -----
// Package for the seven-segment readout pixel core: widths, layout constants,
// the segment and reciprocal tables, and the layout descriptor passed between stages.
// Depends on nothing; every other file of the block uses it.
package ssrp_pkg;

  // Field widths of the request and response.
  localparam int unsigned ValW   = 17;
  localparam int unsigned ColW   = 10;
  localparam int unsigned RowW   = 9;
  localparam int unsigned ColorW = 8;

  // Signed offsets of the pixel from the display origin.
  localparam int unsigned DxW = ColW + 1;
  localparam int unsigned DyW = RowW + 1;

  // Largest reading shown on the display.
  localparam logic [ValW-1:0] MaxReading = 17'd99999;

  // Layout of the 33x7 readout.
  localparam int unsigned NumCells   = 5;
  localparam int unsigned CellW      = 4;
  localparam int unsigned CellH      = 7;
  localparam int unsigned LayoutW    = 33;
  localparam int unsigned PointCol   = 10;
  localparam int unsigned PointColEnd = 12;
  localparam int unsigned PointRow   = 5;
  localparam int unsigned VeeCol     = 29;
  localparam int unsigned VeeMidRow  = 4;

  // Digit extraction: the cell's power of ten is divided out with a reciprocal,
  // then the last decimal digit is split off with a second reciprocal of ten.
  localparam int unsigned RecipW     = 32;
  localparam int unsigned RecipShift = 31;
  localparam int unsigned ProdW      = ValW + RecipW;
  localparam int unsigned Div10W     = 18;
  localparam int unsigned Div10Shift = 21;
  localparam int unsigned Div10ProdW = ValW + Div10W;
  localparam int unsigned TensW      = Div10ProdW - Div10Shift;
  localparam logic [Div10W-1:0] Div10Mult = 18'd209716;

  // Segment bit positions inside a pattern.
  localparam int unsigned SegA = 0;
  localparam int unsigned SegB = 1;
  localparam int unsigned SegC = 2;
  localparam int unsigned SegD = 3;
  localparam int unsigned SegE = 4;
  localparam int unsigned SegF = 5;
  localparam int unsigned SegG = 6;

  // Fixed colors.
  localparam logic [ColorW-1:0] LitRed     = 8'd0;
  localparam logic [ColorW-1:0] LitGreen   = 8'd255;
  localparam logic [ColorW-1:0] LitBlue    = 8'd0;
  localparam logic [ColorW-1:0] DarkRed    = 8'd10;
  localparam logic [ColorW-1:0] DarkGreen  = 8'd30;
  localparam logic [ColorW-1:0] DarkBlue   = 8'd10;
  localparam logic [ColorW-1:0] GlowAlpha  = 8'd100;
  localparam logic [ColorW-1:0] GlowGreen  = 8'd200;
  localparam logic [ColorW-1:0] GlowNone   = 8'd0;

  // Which layout element a pixel falls on.
  typedef enum logic [1:0] {
    KindNone,
    KindPoint,
    KindVee,
    KindDigit
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] digit_idx;
    logic [1:0] cx;
    logic [2:0] cy;
  } layout_t;

  // Left column of each digit cell, most significant digit first.
  function automatic logic [5:0] cell_col(input logic [2:0] idx);
    logic [5:0] c;
    case (idx)
      3'd0:    c = 6'd0;
      3'd1:    c = 6'd5;
      3'd2:    c = 6'd13;
      3'd3:    c = 6'd18;
      3'd4:    c = 6'd23;
      default: c = 6'd0;
    endcase
    return c;
  endfunction

  // ceil(2^31 / 10^(4-idx)); exact quotients for every reading up to MaxReading.
  function automatic logic [RecipW-1:0] recip(input logic [2:0] idx);
    logic [RecipW-1:0] r;
    case (idx)
      3'd0:    r = 32'd214749;
      3'd1:    r = 32'd2147484;
      3'd2:    r = 32'd21474837;
      3'd3:    r = 32'd214748365;
      3'd4:    r = 32'h8000_0000;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Seven-segment patterns, bit 0 is the top segment.
  function automatic logic [6:0] seg_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0:    p = 7'b0111111;
      4'd1:    p = 7'b0000110;
      4'd2:    p = 7'b1011011;
      4'd3:    p = 7'b1001111;
      4'd4:    p = 7'b1100110;
      4'd5:    p = 7'b1101101;
      4'd6:    p = 7'b1111101;
      4'd7:    p = 7'b0000111;
      4'd8:    p = 7'b1111111;
      4'd9:    p = 7'b1101111;
      default: p = 7'b0000000;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/ssrp_if.sv -----
// Request and response channels of the seven-segment readout pixel core.
// Depends on ssrp_pkg for the field widths.
interface ssrp_req_if;
  logic                          valid;
  logic                          ready;
  logic [ssrp_pkg::ValW-1:0]     reading_mv;
  logic [ssrp_pkg::ColW-1:0]     pixel_col;
  logic [ssrp_pkg::RowW-1:0]     pixel_row;
  logic [ssrp_pkg::ColW-1:0]     origin_col;
  logic [ssrp_pkg::RowW-1:0]     origin_row;

  modport source (output valid, reading_mv, pixel_col, pixel_row, origin_col, origin_row,
                  input ready);
  modport sink   (input valid, reading_mv, pixel_col, pixel_row, origin_col, origin_row,
                  output ready);
endinterface

interface ssrp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          lit;
  logic [ssrp_pkg::ColorW-1:0]   red;
  logic [ssrp_pkg::ColorW-1:0]   green;
  logic [ssrp_pkg::ColorW-1:0]   blue;
  logic [ssrp_pkg::ColorW-1:0]   glow_alpha;
  logic [ssrp_pkg::ColorW-1:0]   glow_green;
  logic                          glow_set;

  modport source (output valid, lit, red, green, blue, glow_alpha, glow_green, glow_set,
                  input ready);
  modport sink   (input valid, lit, red, green, blue, glow_alpha, glow_green, glow_set,
                  output ready);
endinterface

// ----- hw/rtl/ssrp_layout.sv -----
// Layout decoder: maps the pixel offset from the origin to a layout element
// and the position inside it. Depends on ssrp_pkg.
module ssrp_layout (
  input  logic signed [ssrp_pkg::DxW-1:0] dx_i,
  input  logic signed [ssrp_pkg::DyW-1:0] dy_i,
  output ssrp_pkg::layout_t               layout_o
);

  logic       in_rows;
  logic       in_span;
  logic [5:0] col;
  logic [2:0] row;

  // Offsets left of or above the origin are negative and fall outside.
  assign in_rows = !dy_i[ssrp_pkg::DyW-1] &&
                   (dy_i[ssrp_pkg::DyW-2:0] < (ssrp_pkg::DyW-1)'(ssrp_pkg::CellH));
  assign in_span = !dx_i[ssrp_pkg::DxW-1] &&
                   (dx_i[ssrp_pkg::DxW-2:0] < (ssrp_pkg::DxW-1)'(ssrp_pkg::LayoutW));
  assign col = dx_i[5:0];
  assign row = dy_i[2:0];

  // Pick the element; the cells do not overlap, so at most one matches.
  always_comb begin
    layout_o.kind      = ssrp_pkg::KindNone;
    layout_o.digit_idx = 3'd0;
    layout_o.cx        = 2'd0;
    layout_o.cy        = row;
    if (in_rows && in_span) begin
      if (col >= 6'(ssrp_pkg::PointCol) && col < 6'(ssrp_pkg::PointColEnd) &&
          row >= 3'(ssrp_pkg::PointRow)) begin
        layout_o.kind = ssrp_pkg::KindPoint;
      end else if (col >= 6'(ssrp_pkg::VeeCol)) begin
        layout_o.kind = ssrp_pkg::KindVee;
        layout_o.cx   = 2'(col - 6'(ssrp_pkg::VeeCol));
      end else begin
        for (int k = 0; k < ssrp_pkg::NumCells; k++) begin
          if (col >= ssrp_pkg::cell_col(3'(k)) &&
              col < ssrp_pkg::cell_col(3'(k)) + 6'(ssrp_pkg::CellW)) begin
            layout_o.kind      = ssrp_pkg::KindDigit;
            layout_o.digit_idx = 3'(k);
            layout_o.cx        = 2'(col - ssrp_pkg::cell_col(3'(k)));
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/ssrp_seg.sv -----
// Pixel shader for one layout element: segment lookup inside a digit cell,
// the letter V shape and the decimal point. Depends on ssrp_pkg.
module ssrp_seg (
  input  ssrp_pkg::layout_t layout_i,
  input  logic [3:0]        digit_i,
  output logic              lit_o
);

  logic [6:0] pat;
  logic       mid;
  logic       left_col;
  logic       right_col;
  logic       seg_lit;
  logic       vee_lit;

  assign pat       = ssrp_pkg::seg_pattern(digit_i);
  assign mid       = (layout_i.cx == 2'd1) || (layout_i.cx == 2'd2);
  assign left_col  = (layout_i.cx == 2'd0);
  assign right_col = (layout_i.cx == 2'd3);

  // Segment under the pixel, by row band of the 4x7 cell.
  always_comb begin
    case (layout_i.cy)
      3'd0:       seg_lit = mid && pat[ssrp_pkg::SegA];
      3'd1, 3'd2: seg_lit = (left_col && pat[ssrp_pkg::SegF]) ||
                            (right_col && pat[ssrp_pkg::SegB]);
      3'd3:       seg_lit = mid && pat[ssrp_pkg::SegG];
      3'd4, 3'd5: seg_lit = (left_col && pat[ssrp_pkg::SegE]) ||
                            (right_col && pat[ssrp_pkg::SegC]);
      3'd6:       seg_lit = mid && pat[ssrp_pkg::SegD];
      default:    seg_lit = 1'b0;
    endcase
  end

  // The V: outer columns above its tip, inner columns at the tip.
  assign vee_lit = (layout_i.cy <= 3'(ssrp_pkg::VeeMidRow)) ? (left_col || right_col) : mid;

  always_comb begin
    case (layout_i.kind)
      ssrp_pkg::KindPoint: lit_o = 1'b1;
      ssrp_pkg::KindVee:   lit_o = vee_lit;
      ssrp_pkg::KindDigit: lit_o = seg_lit;
      default:             lit_o = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/seven_segment_readout_pixel_core.sv -----
// Top level of the seven-segment readout pixel core: five-stage pipeline.
// Depends on ssrp_pkg, ssrp_if, ssrp_layout and ssrp_seg.
//
//   Channel  Modport  Direction  Carries
//   req_i    sink     in         reading_mv, pixel_col, pixel_row, origin_col, origin_row
//   rsp_o    source   out        lit, red, green, blue, glow_alpha, glow_green, glow_set
//
// One request enters per clock unless a stalled output has filled the pipeline; its response leaves from stage five.
// Stage one clamps and offsets, two decodes the layout, three and four each hold one
// reciprocal multiplier of the digit split, five looks up the segment.
// Reset clears the stage valid bits only; the block takes requests right after it.
// A stalled response holds the unbroken run of full stages behind it; a full stage
// with an empty stage ahead still advances, so bubbles are squeezed out.
module seven_segment_readout_pixel_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  ssrp_req_if.sink            req_i,
  ssrp_rsp_if.source          rsp_o
);

  // Stage enables: a stage loads when it is empty or the next one loads.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || rsp_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign req_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= req_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: clamp the reading and take the offsets from the origin.
  logic [ssrp_pkg::ValW-1:0]       val1_d, val1_q;
  logic signed [ssrp_pkg::DxW-1:0] dx1_d, dx1_q;
  logic signed [ssrp_pkg::DyW-1:0] dy1_d, dy1_q;

  assign val1_d = (req_i.reading_mv > ssrp_pkg::MaxReading) ? ssrp_pkg::MaxReading
                                                            : req_i.reading_mv;
  assign dx1_d  = signed'({1'b0, req_i.pixel_col}) - signed'({1'b0, req_i.origin_col});
  assign dy1_d  = signed'({1'b0, req_i.pixel_row}) - signed'({1'b0, req_i.origin_row});

  // Stage 2: layout decode.
  ssrp_pkg::layout_t         lay2_d, lay2_q;
  logic [ssrp_pkg::ValW-1:0] val2_q;

  ssrp_layout u_layout (
    .dx_i     (dx1_q),
    .dy_i     (dy1_q),
    .layout_o (lay2_d)
  );

  // Stage 3: divide by the cell's power of ten.
  logic [ssrp_pkg::ProdW-1:0] prod3;
  logic [ssrp_pkg::ValW-1:0]  quot3_d, quot3_q;
  ssrp_pkg::layout_t          lay3_q;

  assign prod3   = ssrp_pkg::ProdW'(val2_q) *
                   ssrp_pkg::ProdW'(ssrp_pkg::recip(lay2_q.digit_idx));
  assign quot3_d = prod3[ssrp_pkg::RecipShift +: ssrp_pkg::ValW];

  // Stage 4: divide the quotient by ten.
  logic [ssrp_pkg::Div10ProdW-1:0] prod4;
  logic [ssrp_pkg::TensW-1:0]      tens4_d, tens4_q;
  logic [3:0]                      qlo4_q;
  ssrp_pkg::layout_t               lay4_q;

  assign prod4   = ssrp_pkg::Div10ProdW'(quot3_q) *
                   ssrp_pkg::Div10ProdW'(ssrp_pkg::Div10Mult);
  assign tens4_d = prod4[ssrp_pkg::Div10Shift +: ssrp_pkg::TensW];

  // Stage 5: the digit is the remainder; shade the pixel.
  logic [ssrp_pkg::TensW+3:0] ten_x;
  logic [3:0]                 digit5;
  logic                       lit5_d, lit5_q;

  assign ten_x  = (ssrp_pkg::TensW+4)'({tens4_q, 3'b000}) +
                  (ssrp_pkg::TensW+4)'({tens4_q, 1'b0});
  assign digit5 = qlo4_q - ten_x[3:0];

  ssrp_seg u_seg (
    .layout_i (lay4_q),
    .digit_i  (digit5),
    .lit_o    (lit5_d)
  );

  // Payload registers, loaded when their stage takes a valid request.
  always_ff @(posedge clk_i) begin
    if (en1 && req_i.valid) begin
      val1_q <= val1_d;
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
    end
    if (en2 && v1_q) begin
      lay2_q <= lay2_d;
      val2_q <= val1_q;
    end
    if (en3 && v2_q) begin
      lay3_q  <= lay2_q;
      quot3_q <= quot3_d;
    end
    if (en4 && v3_q) begin
      lay4_q  <= lay3_q;
      tens4_q <= tens4_d;
      qlo4_q  <= quot3_q[3:0];
    end
    if (en5 && v4_q) begin
      lit5_q <= lit5_d;
    end
  end

  // Response: colors follow from the lit flag.
  assign rsp_o.valid      = v5_q;
  assign rsp_o.lit        = lit5_q;
  assign rsp_o.red        = lit5_q ? ssrp_pkg::LitRed   : ssrp_pkg::DarkRed;
  assign rsp_o.green      = lit5_q ? ssrp_pkg::LitGreen : ssrp_pkg::DarkGreen;
  assign rsp_o.blue       = lit5_q ? ssrp_pkg::LitBlue  : ssrp_pkg::DarkBlue;
  assign rsp_o.glow_alpha = lit5_q ? ssrp_pkg::GlowAlpha : ssrp_pkg::GlowNone;
  assign rsp_o.glow_green = lit5_q ? ssrp_pkg::GlowGreen : ssrp_pkg::GlowNone;
  assign rsp_o.glow_set   = lit5_q;

endmodule

// ----- hw/rtl/ssrp_checker.sv -----
// Port-level checker for the seven-segment readout pixel core, with its bind.
// Depends on ssrp_pkg and on the core's request and response channels.
module ssrp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          rsp_lit_i,
  input logic [ssrp_pkg::ColorW-1:0]   rsp_red_i,
  input logic [ssrp_pkg::ColorW-1:0]   rsp_green_i,
  input logic [ssrp_pkg::ColorW-1:0]   rsp_blue_i,
  input logic [ssrp_pkg::ColorW-1:0]   rsp_glow_alpha_i,
  input logic [ssrp_pkg::ColorW-1:0]   rsp_glow_green_i,
  input logic                          rsp_glow_set_i
);

  // A response held by back-pressure keeps its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_lit_i))
    else $error("stalled response changed");

  // The core only refuses a request when its pipeline is full and the output stalls.
  assert property (@(posedge clk_i)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("request refused while the pipeline has room");

  // A lit pixel carries the lit colors and the glow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_lit_i |->
      rsp_red_i == ssrp_pkg::LitRed && rsp_green_i == ssrp_pkg::LitGreen &&
      rsp_blue_i == ssrp_pkg::LitBlue && rsp_glow_alpha_i == ssrp_pkg::GlowAlpha &&
      rsp_glow_green_i == ssrp_pkg::GlowGreen && rsp_glow_set_i)
    else $error("lit pixel with wrong colors");

  // A dark pixel carries the background colors and no glow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_lit_i |->
      rsp_red_i == ssrp_pkg::DarkRed && rsp_green_i == ssrp_pkg::DarkGreen &&
      rsp_blue_i == ssrp_pkg::DarkBlue && rsp_glow_alpha_i == ssrp_pkg::GlowNone &&
      rsp_glow_green_i == ssrp_pkg::GlowNone && !rsp_glow_set_i)
    else $error("dark pixel with wrong colors");

endmodule

bind seven_segment_readout_pixel_core ssrp_checker u_ssrp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_lit_i        (rsp_o.lit),
  .rsp_red_i        (rsp_o.red),
  .rsp_green_i      (rsp_o.green),
  .rsp_blue_i       (rsp_o.blue),
  .rsp_glow_alpha_i (rsp_o.glow_alpha),
  .rsp_glow_green_i (rsp_o.glow_green),
  .rsp_glow_set_i   (rsp_o.glow_set)
);
